// ===== hdl/ufrt_pkg.sv =====
package ufrt_pkg;

   // Window geometry and frame limits
   localparam int WINDOW_SLOTS   = 16;
   localparam int MAX_FRAGMENTS  = 256;
   localparam int FRAGMENT_BYTES = 1024;
   localparam int SLOT_W         = $clog2(WINDOW_SLOTS);
   localparam int FRAG_W         = $clog2(MAX_FRAGMENTS);
   localparam logic [31:0] REPLAY_LIMIT = 32'hC000_0000;

   // Status codes carried in the result
   localparam logic [1:0] ST_BUFFER   = 2'd0;
   localparam logic [1:0] ST_READY    = 2'd1;
   localparam logic [1:0] ST_DISPATCH = 2'd2;

   typedef struct packed {
      logic [15:0] session_tag;
      logic [31:0] sequence_number;
      logic [7:0]  fragment_index;
      logic [7:0]  last_fragment_index;
      logic [10:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        replay_seen;
      logic [3:0]  slot_index;
      logic        store_payload;
      logic [17:0] write_offset;
      logic        duplicate;
      logic        message_complete;
      logic        gap_recovered;
      logic        window_cleared;
      logic [31:0] expected_after;
   } rsp_type;

   // Classification of a frame against the window
   typedef enum logic [2:0] {
      KIND_REPLAY,
      KIND_DISPATCH,
      KIND_WINDOW,
      KIND_GAP,
      KIND_BEYOND
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_CLASS,
      S_SCAN,
      S_GEND,
      S_REC,
      S_FIN
   } state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic scan;
      logic gap_end;
      logic wipe;
      logic record;
      logic emit;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     scan_last;
      logic     out_busy;
   } sts_type;

endpackage

// ===== hdl/ufrt_ctrl.sv =====
module ufrt_ctrl import ufrt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = S_CLASS;
         end
         S_CLASS: begin
            unique case (sts.kind)
               KIND_WINDOW: state_in = S_REC;
               KIND_GAP:    state_in = S_SCAN;
               KIND_BEYOND: begin
                  cmd.wipe = 1'b1;
                  state_in = S_REC;
               end
               default:     state_in = S_FIN;
            endcase
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) state_in = S_GEND;
         end
         S_GEND: begin
            cmd.gap_end = 1'b1;
            state_in    = S_REC;
         end
         S_REC: begin
            cmd.record = 1'b1;
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== hdl/ufrt_datapath.sv =====
module ufrt_datapath import ufrt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   req_type                     in_ff;
   rsp_type                     res_ff, out_ff;
   logic                        out_valid_ff;
   logic [15:0]                 session_ff;
   logic [31:0]                 exp_ff;
   kind_type                    kind_ff;
   logic [WINDOW_SLOTS-1:0]     ready_ff;
   logic [WINDOW_SLOTS-1:0]     row_valid_ff;
   logic [8:0]                  count_ff [WINDOW_SLOTS];
   logic [18:0]                 bytes_ff [WINDOW_SLOTS];
   logic [SLOT_W-1:0]           scan_i_ff;
   logic                        keep_ff;
   logic [31:0]                 next_ff;
   logic [MAX_FRAGMENTS-1:0]    rd_row_ff;
   logic [MAX_FRAGMENTS-1:0]    bitmap [WINDOW_SLOTS];

   logic [31:0]              exp_eff, seq_dist, scan_seq, offset;
   logic [SLOT_W-1:0]        slot, scan_slot;
   logic [MAX_FRAGMENTS-1:0] row, bit_sel;
   logic                     frag_ok, seen, fresh, dispatch_now;
   logic [8:0]               count_new;
   rsp_type                  res_start, res_out;

   assign slot      = in_ff.sequence_number[SLOT_W-1:0];
   assign exp_eff   = (in_ff.session_tag != session_ff) ? in_ff.sequence_number : exp_ff;
   assign seq_dist  = in_ff.sequence_number - exp_eff;
   assign dispatch_now = (seq_dist == 32'd0) && (in_ff.last_fragment_index == 8'd0);
   assign scan_seq  = exp_ff + 32'(WINDOW_SLOTS - 1) - 32'(scan_i_ff);
   assign scan_slot = scan_seq[SLOT_W-1:0];
   assign offset    = 32'(in_ff.fragment_index) * 32'(FRAGMENT_BYTES);
   assign frag_ok   = {1'b0, in_ff.fragment_index} < 9'(MAX_FRAGMENTS);
   assign row       = row_valid_ff[slot] ? rd_row_ff : '0;
   assign bit_sel   = MAX_FRAGMENTS'(1) << in_ff.fragment_index[FRAG_W-1:0];
   assign seen      = |(row & bit_sel);
   assign fresh     = frag_ok && !seen;
   assign count_new = count_ff[slot] + 9'd1;

   assign sts.kind      = kind_ff;
   assign sts.scan_last = (scan_i_ff == SLOT_W'(WINDOW_SLOTS - 1));
   assign sts.out_busy  = out_valid_ff && !rsp_ready;
   assign rsp_valid     = out_valid_ff;
   assign rsp_data      = out_ff;

   // Fragment bitmap, one row per slot
   always_ff @(posedge clock) begin
      if (cmd.lookup) rd_row_ff <= bitmap[slot];
      if (cmd.record && fresh) bitmap[slot] <= row | bit_sel;
   end

   // Header capture
   always_ff @(posedge clock) begin
      if (cmd.capture) in_ff <= req_data;
   end

   // Sequencing and slot state
   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff   <= '0;
         exp_ff       <= '0;
         ready_ff     <= '0;
         row_valid_ff <= '0;
         kind_ff      <= KIND_REPLAY;
         scan_i_ff    <= '0;
         keep_ff      <= 1'b1;
         next_ff      <= '0;
         for (int i = 0; i < WINDOW_SLOTS; i++) begin
            count_ff[i] <= '0;
            bytes_ff[i] <= '0;
         end
      end else begin
         if (cmd.lookup) begin
            session_ff <= in_ff.session_tag;
            scan_i_ff  <= '0;
            keep_ff    <= 1'b1;
            next_ff    <= in_ff.sequence_number;
            exp_ff     <= dispatch_now ? exp_eff + 32'd1 : exp_eff;
            if (seq_dist > REPLAY_LIMIT) kind_ff <= KIND_REPLAY;
            else if (dispatch_now) kind_ff <= KIND_DISPATCH;
            else if (seq_dist < 32'(WINDOW_SLOTS)) kind_ff <= KIND_WINDOW;
            else if (seq_dist == 32'(WINDOW_SLOTS)) kind_ff <= KIND_GAP;
            else kind_ff <= KIND_BEYOND;
         end
         // gap recovery walks down from the top of the window
         if (cmd.scan) begin
            scan_i_ff <= scan_i_ff + SLOT_W'(1);
            if (keep_ff && ready_ff[scan_slot]) next_ff <= scan_seq;
            else begin
               keep_ff                 <= 1'b0;
               ready_ff[scan_slot]     <= 1'b0;
               row_valid_ff[scan_slot] <= 1'b0;
               count_ff[scan_slot]     <= '0;
               bytes_ff[scan_slot]     <= '0;
            end
         end
         if (cmd.gap_end && !keep_ff) exp_ff <= next_ff;
         if (cmd.wipe || (cmd.gap_end && keep_ff)) begin
            exp_ff       <= in_ff.sequence_number;
            ready_ff     <= '0;
            row_valid_ff <= '0;
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
               count_ff[i] <= '0;
               bytes_ff[i] <= '0;
            end
         end
         if (cmd.record && fresh) begin
            row_valid_ff[slot] <= 1'b1;
            count_ff[slot]     <= count_new;
            if (in_ff.fragment_index == in_ff.last_fragment_index)
               bytes_ff[slot] <= 19'(offset + 32'(in_ff.payload_length));
            if (count_new == {1'b0, in_ff.last_fragment_index} + 9'd1)
               ready_ff[slot] <= 1'b1;
         end
      end
   end

   // Initial result of a header at lookup
   always_comb begin
      res_start            = '0;
      res_start.slot_index = 4'(slot);
      if (seq_dist > REPLAY_LIMIT) begin
         res_start.status      = ST_READY;
         res_start.replay_seen = 1'b1;
      end else if (dispatch_now) res_start.status = ST_DISPATCH;
   end

   // Working result
   always_ff @(posedge clock) begin
      if (cmd.lookup) res_ff <= res_start;
      if (cmd.gap_end) begin
         res_ff.gap_recovered <= 1'b1;
         if (keep_ff) res_ff.window_cleared <= 1'b1;
      end
      if (cmd.wipe) res_ff.window_cleared <= 1'b1;
      if (cmd.record && frag_ok) begin
         if (seen) res_ff.duplicate <= 1'b1;
         else begin
            res_ff.store_payload <= 1'b1;
            res_ff.write_offset  <= offset[17:0];
            if (count_new == {1'b0, in_ff.last_fragment_index} + 9'd1) begin
               res_ff.message_complete <= 1'b1;
               if (in_ff.sequence_number == exp_ff) res_ff.status <= ST_READY;
            end
         end
      end
   end

   // Result with the expected number attached
   always_comb begin
      res_out                = res_ff;
      res_out.expected_after = exp_ff;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.emit) out_valid_ff <= 1'b1;
      else if (rsp_ready) out_valid_ff <= 1'b0;
      if (cmd.emit) out_ff <= res_out;
   end

endmodule

// ===== hdl/udp_fragment_reorder_tracker_core.sv =====
// Frame header tracker for a fragmented, reordering datagram stream.
// req_*: one header per transfer (session, sequence, fragment index,
//   last fragment index, payload length), valid/ready.
// rsp_*: one result per header: status, replay and duplicate flags, ring
//   slot, payload write offset, completion and window flags and the
//   expected sequence number afterwards.
// A replay or direct dispatch is captured, looked up, classified and
//   emitted; a recorded fragment also passes the bitmap record step; the
//   recovery of a gap of one full window adds a scan (one slot examined
//   per cycle) and a gap end step before the record. One header is
//   worked at a time; the next is taken once the result sits in the
//   output register. The finish step waits while a stalled receiver
//   still holds the previous result.
// Reset clears session, expected number and all slot state; the fragment
//   bitmap rows are marked empty by per-slot valid flags, so no sweep.
// A stalled receiver holds the result; the block still takes one more
//   header and works it up to the point of handing over its result.
module udp_fragment_reorder_tracker_core import ufrt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   ufrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ufrt_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("header taken while another is in work");

   a_replay_inert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.replay_seen |->
         rsp_data.status == ST_READY && !rsp_data.store_payload && !rsp_data.duplicate)
      else $error("replayed frame changed state");

   a_store_xor_dup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.store_payload && rsp_data.duplicate))
      else $error("fragment both stored and dropped");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import ufrt_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   udp_fragment_reorder_tracker_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Predictor state
   logic [15:0] trk_session;
   logic [31:0] trk_expected;
   logic        trk_ready [WINDOW_SLOTS];
   logic [8:0]  trk_count [WINDOW_SLOTS];
   logic [18:0] trk_bytes [WINDOW_SLOTS];
   logic        trk_seen  [WINDOW_SLOTS][MAX_FRAGMENTS];

   req_type pending_headers[$];
   rsp_type expected_results[$];
   int      errors;
   int      send_idle_pct;
   int      recv_stall_pct;
   int      hold_off_cycles;

   // Stimulus stream state
   logic [15:0] gen_session;
   logic [31:0] gen_base;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic void clear_slot_state(input int s);
      trk_ready[s] = 1'b0;
      trk_count[s] = '0;
      trk_bytes[s] = '0;
      for (int f = 0; f < MAX_FRAGMENTS; f++) trk_seen[s][f] = 1'b0;
   endfunction

   function automatic void reset_tracker();
      trk_session  = '0;
      trk_expected = '0;
      for (int s = 0; s < WINDOW_SLOTS; s++) clear_slot_state(s);
   endfunction

   function automatic void record_fragment(input req_type h, inout rsp_type r);
      int          s;
      logic [31:0] offset;
      s = int'(h.sequence_number[SLOT_W-1:0]);
      if (trk_seen[s][h.fragment_index]) begin
         r.duplicate = 1'b1;
         return;
      end
      trk_seen[s][h.fragment_index] = 1'b1;
      offset = 32'(h.fragment_index) * FRAGMENT_BYTES;
      r.store_payload = 1'b1;
      r.write_offset  = offset[17:0];
      if (h.fragment_index == h.last_fragment_index)
         trk_bytes[s] = 19'(offset + 32'(h.payload_length));
      trk_count[s] = trk_count[s] + 9'd1;
      if (trk_count[s] == 9'(h.last_fragment_index) + 9'd1) begin
         trk_ready[s] = 1'b1;
         r.message_complete = 1'b1;
         if (h.sequence_number == trk_expected) r.status = ST_READY;
      end
   endfunction

   // Work out the result of one header and advance the predictor
   function automatic rsp_type track_header(input req_type h);
      rsp_type     r;
      logic [31:0] seq_dist, nxt, s;
      bit          keep, full;
      r = '0;
      r.status = ST_BUFFER;
      r.slot_index = h.sequence_number[3:0];
      if (h.session_tag != trk_session) begin
         trk_session  = h.session_tag;
         trk_expected = h.sequence_number;
      end
      seq_dist = h.sequence_number - trk_expected;
      if (seq_dist > REPLAY_LIMIT) begin
         r.status = ST_READY;
         r.replay_seen = 1'b1;
      end else if (seq_dist == 0 && h.last_fragment_index == 0) begin
         trk_expected = trk_expected + 1;
         r.status = ST_DISPATCH;
      end else if (seq_dist < WINDOW_SLOTS) begin
         record_fragment(h, r);
      end else begin
         full = 1'b0;
         if (seq_dist == WINDOW_SLOTS) begin
            nxt  = h.sequence_number;
            keep = 1'b1;
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
               s = trk_expected + 32'(WINDOW_SLOTS - i - 1);
               if (keep && trk_ready[s[SLOT_W-1:0]]) begin
                  nxt = s;
               end else begin
                  keep = 1'b0;
                  clear_slot_state(int'(s[SLOT_W-1:0]));
               end
            end
            r.gap_recovered = 1'b1;
            if (keep) full = 1'b1;
            else trk_expected = nxt;
         end
         if (seq_dist != WINDOW_SLOTS || full) begin
            for (int i = 0; i < WINDOW_SLOTS; i++) clear_slot_state(i);
            trk_expected = h.sequence_number;
            r.window_cleared = 1'b1;
         end
         record_fragment(h, r);
      end
      r.expected_after = trk_expected;
      return r;
   endfunction

   function automatic req_type make_header(input logic [15:0] tag, input logic [31:0] sn,
                                          input logic [7:0] fi, input logic [7:0] lf,
                                          input logic [10:0] len);
      req_type h;
      h.session_tag = tag;
      h.sequence_number = sn;
      h.fragment_index = fi;
      h.last_fragment_index = lf;
      h.payload_length = len;
      return h;
   endfunction

   // One random header, mostly within or near the current window
   function automatic req_type random_header();
      int          pick;
      logic [31:0] sn;
      logic [7:0]  lf;
      pick = $urandom_range(99);
      if (pick < 2) gen_session = 16'($urandom);
      if (pick < 40) begin
         sn = gen_base;
         gen_base = gen_base + 32'($urandom_range(3) == 0);
      end else if (pick < 75) sn = gen_base + $urandom_range(15);
      else if (pick < 83) sn = gen_base + 16;
      else if (pick < 90) sn = gen_base - $urandom_range(40);
      else if (pick < 95) begin
         sn = $urandom;
         gen_base = sn;
      end else sn = gen_base + $urandom_range(17, 2000);
      lf = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      if ($urandom_range(2) == 0) lf = '0;
      return make_header(gen_session, sn,
                         ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(lf)),
                         lf, ($urandom_range(7) == 0) ? 11'($urandom) : 11'($urandom_range(1024)));
   endfunction

   // Driver: pops pending headers, holds valid until the transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_headers.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_headers.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predict at the accepting edge, in transfer order
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         expected_results.push_back(track_header(req_data));
   end

   // Long receiver hold-off counter
   always @(posedge clock) begin
      if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
   end

   // Monitor and receiver stall
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with nothing expected");
               errors++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_data.status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_data.status); errors++; end
               if (rsp_data.replay_seen !== e.replay_seen) begin
                  $error("replay_seen exp %0d got %0d", e.replay_seen, rsp_data.replay_seen);
                  errors++; end
               if (rsp_data.slot_index !== e.slot_index) begin
                  $error("slot_index exp %0d got %0d", e.slot_index, rsp_data.slot_index);
                  errors++; end
               if (rsp_data.store_payload !== e.store_payload) begin
                  $error("store_payload exp %0d got %0d", e.store_payload,
                         rsp_data.store_payload); errors++; end
               if (rsp_data.write_offset !== e.write_offset) begin
                  $error("write_offset exp %0d got %0d", e.write_offset,
                         rsp_data.write_offset); errors++; end
               if (rsp_data.duplicate !== e.duplicate) begin
                  $error("duplicate exp %0d got %0d", e.duplicate, rsp_data.duplicate);
                  errors++; end
               if (rsp_data.message_complete !== e.message_complete) begin
                  $error("message_complete exp %0d got %0d", e.message_complete,
                         rsp_data.message_complete); errors++; end
               if (rsp_data.gap_recovered !== e.gap_recovered) begin
                  $error("gap_recovered exp %0d got %0d", e.gap_recovered,
                         rsp_data.gap_recovered); errors++; end
               if (rsp_data.window_cleared !== e.window_cleared) begin
                  $error("window_cleared exp %0d got %0d", e.window_cleared,
                         rsp_data.window_cleared); errors++; end
               if (rsp_data.expected_after !== e.expected_after) begin
                  $error("expected_after exp %0h got %0h", e.expected_after,
                         rsp_data.expected_after); errors++; end
            end
         end
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic wait_drained();
      while (pending_headers.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
   endtask

   task automatic run_random(input int n, input int idle, input int stall);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n; i++) pending_headers.push_back(random_header());
      wait_drained();
   endtask

   initial begin
      errors = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      reset = 1'b1;
      reset_tracker();
      gen_session = 16'h0001;
      gen_base = 32'd100;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: dispatch, fragments, duplicate, ready slot refilled,
      // largest fragment index, gap recovery, large gap, replay, extremes
      pending_headers.push_back(make_header(16'h0000, 32'd0, 8'd0, 8'd0, 11'd0));
      pending_headers.push_back(make_header(16'hFFFF, 32'hFFFF_FFFE, 8'd0, 8'd0, 11'd1024));
      pending_headers.push_back(make_header(16'hFFFF, 32'hFFFF_FFFF, 8'd1, 8'd1, 11'h7FF));
      pending_headers.push_back(make_header(16'hFFFF, 32'hFFFF_FFFF, 8'd1, 8'd1, 11'd5));
      pending_headers.push_back(make_header(16'hFFFF, 32'hFFFF_FFFF, 8'd0, 8'd1, 11'd7));
      pending_headers.push_back(make_header(16'hFFFF, 32'h0000_0003, 8'd255, 8'd255, 11'h7FF));
      pending_headers.push_back(make_header(16'hFFFF, 32'h0000_0004, 8'd0, 8'd0, 11'd3));
      pending_headers.push_back(make_header(16'hFFFF, 32'hFFFF_FFF0, 8'd0, 8'd0, 11'd1));
      pending_headers.push_back(make_header(16'hFFFF, 32'h0000_000F, 8'd2, 8'd2, 11'd9));
      pending_headers.push_back(make_header(16'hFFFF, 32'h0000_000F, 8'd2, 8'd2, 11'd9));
      pending_headers.push_back(make_header(16'h1234, 32'h8000_0000, 8'd0, 8'd0, 11'd0));
      pending_headers.push_back(make_header(16'h1234, 32'h8000_0011, 8'd0, 8'd0, 11'd1));
      pending_headers.push_back(make_header(16'h1234, 32'h8000_0003, 8'd0, 8'd1, 11'd2));
      pending_headers.push_back(make_header(16'h1234, 32'h8000_0003, 8'd1, 8'd1, 11'd2));
      pending_headers.push_back(make_header(16'h1234, 32'h8000_0013, 8'd0, 8'd0, 11'd4));
      pending_headers.push_back(make_header(16'h1234, 32'h8000_0100, 8'd0, 8'd2, 11'd4));
      pending_headers.push_back(make_header(16'h1234, 32'h4000_0100, 8'd0, 8'd0, 11'd4));
      pending_headers.push_back(make_header(16'h1234, 32'hC000_0100, 8'd0, 8'd0, 11'd4));
      // Fill every slot ready, then a gap of exactly one window
      pending_headers.push_back(make_header(16'h0042, 32'd1000, 8'd0, 8'd1, 11'd8));
      for (int i = 1; i < 16; i++)
         pending_headers.push_back(make_header(16'h0042, 32'(1000 + i), 8'd0, 8'd0, 11'd8));
      pending_headers.push_back(make_header(16'h0042, 32'd1000, 8'd1, 8'd1, 11'd8));
      pending_headers.push_back(make_header(16'h0042, 32'd1016, 8'd0, 8'd1, 11'd8));
      wait_drained();

      // Long receiver hold-off while headers keep coming
      hold_off_cycles = 300;
      run_random(40, 0, 0);

      gen_session = 16'h0042;
      gen_base = 32'd2000;
      run_random(300, 0, 0);
      run_random(300, 72, 0);
      run_random(300, 0, 72);
      run_random(300, 6, 6);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== udp_fragment_reorder_tracker_core.f =====
hdl/ufrt_pkg.sv
hdl/ufrt_ctrl.sv
hdl/ufrt_datapath.sv
hdl/udp_fragment_reorder_tracker_core.sv
sim/testbench.sv
